// File: rtl/assert_macros.svh
// Assertion macros shared by the caster RTL.
// Used by the controller and datapath files; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define GRC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent followed by a consequent in the next cycle.
`define GRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/grc_pkg.sv
// Types, constants and codes for the grid ray caster.
// No dependencies; used by grc_ctrl, grc_dp and the top level.
package grc_pkg;

   localparam int MAP_SIDE      = 32;
   localparam int POS_FRAC_BITS = 11;
   localparam int CELL_W        = $clog2(MAP_SIDE);
   localparam int MAP_DEPTH     = MAP_SIDE * MAP_SIDE;
   localparam int ADDR_W        = $clog2(MAP_DEPTH);
   localparam int MAX_STEPS     = 2 * MAP_SIDE + 2;
   localparam int STEP_W        = $clog2(MAX_STEPS + 1);
   localparam int COORD_W       = CELL_W + 2;
   localparam int POS_W         = 16;
   localparam int DIR_W         = 16;
   localparam int DELTA_W       = 16;
   localparam int SIDE_W        = POS_FRAC_BITS + 1 + DELTA_W + STEP_W + 1;
   localparam int MAG_W         = CELL_W + POS_FRAC_BITS + 1;
   localparam int QSH           = 20 - POS_FRAC_BITS;
   localparam int DIVD_W        = MAG_W + QSH;
   localparam int DIV_CNT_W     = $clog2(DIVD_W);
   localparam int REM_W         = DIR_W + 1;
   localparam int DIST_W        = 16;
   localparam int CODE_W        = 8;
   localparam int COLOUR_W      = 3;
   localparam int FACE_W        = 2;

   localparam logic [CODE_W-1:0] CODE_COLOUR_LO = 8'd3;
   localparam logic [CODE_W-1:0] CODE_COLOUR_HI = 8'd5;

   localparam logic [FACE_W-1:0] FACE_XNEG = 2'd0;
   localparam logic [FACE_W-1:0] FACE_YNEG = 2'd1;
   localparam logic [FACE_W-1:0] FACE_XPOS = 2'd2;
   localparam logic [FACE_W-1:0] FACE_YPOS = 2'd3;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_CAST  = 1'b1;

   typedef struct packed {
      logic                      func;
      logic [4:0]                cell_col;
      logic [4:0]                cell_row;
      logic [CODE_W-1:0]         cell_code;
      logic [POS_W-1:0]          ray_pos_x;
      logic [POS_W-1:0]          ray_pos_y;
      logic signed [DIR_W-1:0]   ray_dir_x;
      logic signed [DIR_W-1:0]   ray_dir_y;
      logic [DELTA_W-1:0]        delta_x;
      logic [DELTA_W-1:0]        delta_y;
   } req_type;

   typedef struct packed {
      logic [4:0]                hit_col;
      logic [4:0]                hit_row;
      logic [FACE_W-1:0]         face_side;
      logic [DIST_W-1:0]         wall_distance;
      logic [CODE_W-1:0]         wall_code;
      logic [COLOUR_W-1:0]       colour_index;
      logic                      escaped;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_LOOK,
      ST_DIV,
      ST_FIN_HIT,
      ST_FIN_ESC
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic write;
      logic load;
      logic step;
      logic hit;
      logic div_step;
      logic out_hit;
      logic out_escape;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic outside;
      logic code_nz;
      logic steps_max;
      logic div_done;
   } sts_type;

endpackage

// File: rtl/grc_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module grc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/grc_ctrl.sv
// Control state machine of the ray caster: clear sweep, cell stepping, divide, result.
// Depends on grc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module grc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_func,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output grc_pkg::cmd_type  cmd,
   input  grc_pkg::sts_type  sts
);
   import grc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_func == FUNC_CAST) state_in = ST_STEP;
         end
         ST_STEP: state_in = ST_LOOK;
         ST_LOOK: begin
            priority if (sts.outside)   state_in = ST_FIN_ESC;
            else if (sts.code_nz)       state_in = ST_DIV;
            else if (sts.steps_max)     state_in = ST_FIN_ESC;
            else                        state_in = ST_STEP;
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_FIN_HIT;
         end
         ST_FIN_HIT, ST_FIN_ESC: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.write = accept && (req_func == FUNC_WRITE);
            cmd.load  = accept && (req_func == FUNC_CAST);
         end
         ST_STEP: cmd.step = 1'b1;
         ST_LOOK: cmd.hit = !sts.outside && sts.code_nz;
         ST_DIV: cmd.div_step = 1'b1;
         ST_FIN_HIT: cmd.out_hit = slot_free;
         ST_FIN_ESC: cmd.out_escape = slot_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_hit || cmd.out_escape) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `GRC_ASSERT_IMPL(a_no_overwrite, clock, reset,
      (cmd.out_hit || cmd.out_escape), (!rsp_valid_ff || rsp_ready),
      "result register overwritten while held")
   `GRC_ASSERT_NEXT(a_cast_starts, clock, reset,
      (accept && req_func == FUNC_CAST), (state_ff == ST_STEP),
      "cast transaction did not start stepping")
   `GRC_ASSERT_IMPL(a_ready_idle, clock, reset,
      req_ready, (state_ff == ST_IDLE && !cmd.clear_step),
      "request taken outside idle")

endmodule

// File: rtl/grc_dp.sv
// Datapath of the ray caster: map RAM, side distances, cell walk, serial divider.
// Depends on grc_pkg, grc_ram and assert_macros.svh.
`include "assert_macros.svh"
module grc_dp (
   input  logic              clock,
   input  logic              reset,
   input  grc_pkg::req_type  req_data,
   output grc_pkg::rsp_type  rsp_data,
   input  grc_pkg::cmd_type  cmd,
   output grc_pkg::sts_type  sts
);
   import grc_pkg::*;

   localparam logic [POS_FRAC_BITS:0] ONE = (POS_FRAC_BITS + 1)'(1) << POS_FRAC_BITS;

   logic [ADDR_W-1:0]          clr_cnt_ff, clr_cnt_in;
   logic signed [COORD_W-1:0]  mx_ff, mx_in, my_ff, my_in;
   logic [SIDE_W-1:0]          sdx_ff, sdx_in, sdy_ff, sdy_in;
   logic [DELTA_W-1:0]         ddx_ff, ddy_ff;
   logic [POS_W-1:0]           px_ff, py_ff;
   logic signed [DIR_W-1:0]    dx_ff, dy_ff;
   logic [FACE_W-1:0]          side_ff, side_in;
   logic [STEP_W-1:0]          steps_ff, steps_in;
   logic [CODE_W-1:0]          code_ff;
   logic [COLOUR_W-1:0]        colour_ff;
   logic [REM_W-1:0]           rem_ff;
   logic [DIVD_W-1:0]          quo_ff;
   logic [DIR_W-1:0]           divisor_ff;
   logic [DIV_CNT_W-1:0]       div_cnt_ff;
   logic                       dir_zero_ff;
   rsp_type                    rsp_ff;

   logic [CODE_W-1:0]          rd_data;
   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_waddr;
   logic [CODE_W-1:0]          ram_wdata;
   logic [POS_FRAC_BITS:0]     fx, fy;
   logic                       dxneg, dyneg;

   // hit preparation
   logic                       on_x;
   logic [CELL_W-1:0]          cell_idx;
   logic [POS_W-1:0]           pos;
   logic                       neg;
   logic signed [DIR_W-1:0]    dir;
   logic signed [MAG_W:0]      num;
   logic [MAG_W-1:0]           mag;
   logic [REM_W-1:0]           trial;
   logic                       ge;
   logic [DIST_W-1:0]          dist_sat;

   assign dxneg = req_data.ray_dir_x[DIR_W-1];
   assign dyneg = req_data.ray_dir_y[DIR_W-1];
   assign fx = dxneg ? {1'b0, req_data.ray_pos_x[POS_FRAC_BITS-1:0]}
                     : ONE - {1'b0, req_data.ray_pos_x[POS_FRAC_BITS-1:0]};
   assign fy = dyneg ? {1'b0, req_data.ray_pos_y[POS_FRAC_BITS-1:0]}
                     : ONE - {1'b0, req_data.ray_pos_y[POS_FRAC_BITS-1:0]};

   // map writes come from the clear sweep or a write transaction
   assign ram_we    = cmd.clear_step || cmd.write;
   assign ram_waddr = cmd.clear_step ? clr_cnt_ff
                                     : {req_data.cell_col, req_data.cell_row};
   assign ram_wdata = cmd.clear_step ? '0 : req_data.cell_code;
   assign clr_cnt_in = clr_cnt_ff + ADDR_W'(1);

   // one DDA step
   always_comb begin
      mx_in    = mx_ff;
      my_in    = my_ff;
      sdx_in   = sdx_ff;
      sdy_in   = sdy_ff;
      side_in  = side_ff;
      steps_in = steps_ff;
      if (cmd.step) begin
         steps_in = steps_ff + STEP_W'(1);
         if (sdx_ff < sdy_ff) begin
            sdx_in  = sdx_ff + (SIDE_W'(ddx_ff) << POS_FRAC_BITS);
            mx_in   = dx_ff[DIR_W-1] ? mx_ff - COORD_W'(1) : mx_ff + COORD_W'(1);
            side_in = dx_ff[DIR_W-1] ? FACE_XNEG : FACE_XPOS;
         end else begin
            sdy_in  = sdy_ff + (SIDE_W'(ddy_ff) << POS_FRAC_BITS);
            my_in   = dy_ff[DIR_W-1] ? my_ff - COORD_W'(1) : my_ff + COORD_W'(1);
            side_in = dy_ff[DIR_W-1] ? FACE_YNEG : FACE_YPOS;
         end
      end
   end

   grc_ram #(
      .WIDTH (CODE_W),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr ({mx_in[CELL_W-1:0], my_in[CELL_W-1:0]}),
      .rd_data (rd_data)
   );

   // perpendicular distance numerator on the hit axis
   always_comb begin
      on_x     = (side_ff == FACE_XNEG) || (side_ff == FACE_XPOS);
      cell_idx = on_x ? mx_ff[CELL_W-1:0] : my_ff[CELL_W-1:0];
      pos      = on_x ? px_ff : py_ff;
      dir      = on_x ? dx_ff : dy_ff;
      neg      = dir[DIR_W-1];
      num      = $signed({2'b00, cell_idx, {POS_FRAC_BITS{1'b0}}}) - $signed({2'b00, pos});
      if (neg) num = num + $signed((MAG_W + 1)'(ONE));
      mag      = num[MAG_W] ? MAG_W'(-num) : MAG_W'(num);
   end

   assign trial    = {rem_ff[REM_W-2:0], quo_ff[DIVD_W-1]};
   assign ge       = trial >= {1'b0, divisor_ff};
   assign dist_sat = (dir_zero_ff || (|quo_ff[DIVD_W-1:DIST_W])) ? '1 : quo_ff[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         steps_ff   <= '0;
         div_cnt_ff <= '0;
         colour_ff  <= '0;
      end else begin
         if (cmd.clear_step) clr_cnt_ff <= clr_cnt_in;
         if (cmd.load) begin
            steps_ff <= '0;
         end else begin
            steps_ff <= steps_in;
         end
         if (cmd.hit) begin
            div_cnt_ff <= '0;
            if (rd_data == CODE_COLOUR_LO) begin
               colour_ff <= {1'b0, side_ff};
            end else if (rd_data == CODE_COLOUR_HI) begin
               colour_ff <= {1'b1, side_ff};
            end
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mx_ff   <= COORD_W'(req_data.ray_pos_x[POS_W-1:POS_FRAC_BITS]);
         my_ff   <= COORD_W'(req_data.ray_pos_y[POS_W-1:POS_FRAC_BITS]);
         sdx_ff  <= SIDE_W'(fx) * SIDE_W'(req_data.delta_x);
         sdy_ff  <= SIDE_W'(fy) * SIDE_W'(req_data.delta_y);
         ddx_ff  <= req_data.delta_x;
         ddy_ff  <= req_data.delta_y;
         px_ff   <= req_data.ray_pos_x;
         py_ff   <= req_data.ray_pos_y;
         dx_ff   <= req_data.ray_dir_x;
         dy_ff   <= req_data.ray_dir_y;
         side_ff <= FACE_XNEG;
      end else begin
         mx_ff   <= mx_in;
         my_ff   <= my_in;
         sdx_ff  <= sdx_in;
         sdy_ff  <= sdy_in;
         side_ff <= side_in;
      end
      if (cmd.hit) begin
         code_ff     <= rd_data;
         rem_ff      <= '0;
         quo_ff      <= {mag, {QSH{1'b0}}};
         divisor_ff  <= neg ? DIR_W'(-dir) : DIR_W'(dir);
         dir_zero_ff <= (dir == '0);
      end else if (cmd.div_step) begin
         rem_ff <= ge ? trial - {1'b0, divisor_ff} : trial;
         quo_ff <= {quo_ff[DIVD_W-2:0], ge};
      end
      if (cmd.out_hit) begin
         rsp_ff.hit_col       <= 5'(mx_ff[CELL_W-1:0]);
         rsp_ff.hit_row       <= 5'(my_ff[CELL_W-1:0]);
         rsp_ff.face_side     <= side_ff;
         rsp_ff.wall_distance <= dist_sat;
         rsp_ff.wall_code     <= code_ff;
         rsp_ff.colour_index  <= colour_ff;
         rsp_ff.escaped       <= 1'b0;
      end else if (cmd.out_escape) begin
         rsp_ff.hit_col       <= '0;
         rsp_ff.hit_row       <= '0;
         rsp_ff.face_side     <= '0;
         rsp_ff.wall_distance <= '0;
         rsp_ff.wall_code     <= '0;
         rsp_ff.colour_index  <= colour_ff;
         rsp_ff.escaped       <= 1'b1;
      end
   end

   assign rsp_data = rsp_ff;

   always_comb begin
      sts.clear_done = (clr_cnt_ff == ADDR_W'(MAP_DEPTH - 1));
      sts.outside    = mx_ff[COORD_W-1] || my_ff[COORD_W-1]
                       || (mx_ff[COORD_W-2:0] >= (COORD_W - 1)'(MAP_SIDE))
                       || (my_ff[COORD_W-2:0] >= (COORD_W - 1)'(MAP_SIDE));
      sts.code_nz    = (rd_data != '0);
      sts.steps_max  = (steps_ff == STEP_W'(MAX_STEPS));
      sts.div_done   = (div_cnt_ff == DIV_CNT_W'(DIVD_W - 1));
   end

   `GRC_ASSERT_IMPL(a_steps_bound, clock, reset,
      1'b1, (steps_ff <= STEP_W'(MAX_STEPS)),
      "cell walk exceeded step limit")
   `GRC_ASSERT_IMPL(a_step_inside, clock, reset,
      cmd.step, (!mx_ff[COORD_W-1] && !my_ff[COORD_W-1]),
      "stepping from a cell outside the map")
   `GRC_ASSERT_IMPL(a_div_bound, clock, reset,
      cmd.div_step, (div_cnt_ff <= DIV_CNT_W'(DIVD_W - 1)),
      "divider ran past its last bit")

endmodule

// File: rtl/grid_ray_wall_caster_core.sv
// Top level of the grid DDA ray caster.
// Depends on grc_pkg, grc_ctrl and grc_dp.
//
//  channel  handshake             payload   direction
//  req      req_valid/req_ready   req_data  in  (map write or ray cast)
//  rsp      rsp_valid/rsp_ready   rsp_data  out (one result per cast)
//
// After reset all 1024 map cells are swept to zero; req_ready stays low.
// A map write is done in the idle state as it is accepted. A cast is accepted in
// idle, then walks cells through the map RAM read loop in a step and a look state
// (up to 66 steps), runs the 26-bit serial divider on a hit and ends in a finish state.
// One item is in flight at a time; a held result stalls only the next finish.
module grid_ray_wall_caster_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  grc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output grc_pkg::rsp_type  rsp_data
);
   import grc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   grc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_data.func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   grc_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .sts      (sts)
   );

endmodule
